// ===== src/unr_pkg.sv =====
// Shared types and constants for the reciprocal divider pipeline.
package unr_pkg;

  localparam int unsigned NumW   = 16;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned SeedW  = 10;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned NegdW  = 17;
  localparam int unsigned RecipW = 19;
  localparam int unsigned ProdW  = 36;

  localparam logic [QuotW-1:0] QuotMax  = 17'h1FFFF;
  localparam logic [SeedW-1:0] SeedMin  = 10'h101;
  localparam int unsigned      SeedRows = 256;

  // Input item
  typedef struct packed {
    logic [NumW-1:0] numerator;
    logic [NumW-1:0] divisor;
  } unr_in_t;

  // Result item
  typedef struct packed {
    logic [QuotW-1:0] quotient;
    logic             overflow;
  } unr_out_t;

  // After normalisation
  typedef struct packed {
    logic             ovf;
    logic [QuotW-1:0] num;
    logic [NumW-1:0]  nd;
    logic [IdxW-1:0]  idx;
  } unr_s1_t;

  // After seed lookup
  typedef struct packed {
    logic             ovf;
    logic [QuotW-1:0] num;
    logic [NumW-1:0]  nd;
    logic [SeedW-1:0] x;
  } unr_s2_t;

  // After first Newton-Raphson product
  typedef struct packed {
    logic             ovf;
    logic [QuotW-1:0] num;
    logic [SeedW-1:0] x;
    logic [NegdW-1:0] negd;
  } unr_s3_t;

  // Refined reciprocal
  typedef struct packed {
    logic              ovf;
    logic [QuotW-1:0]  num;
    logic [RecipW-1:0] recip;
  } unr_s4_t;

  // Rounded quotient product
  typedef struct packed {
    logic             ovf;
    logic [ProdW-1:0] prod;
  } unr_s5_t;

endpackage

// ===== src/unr_reciprocal_divider_unit.sv =====
// Top level of the pipelined 16-bit reciprocal divider.
//
// Usage: an input transfer (in_valid_i and in_ready_o high) carries a 16-bit
// numerator and divisor; a result transfer (out_valid_o and out_ready_i
// high) carries a 17-bit quotient in 1.16 fixed point and an overflow flag.
// When twice the divisor does not exceed the numerator (a zero divisor
// included) the flag is set and the quotient reads 0x1FFFF.
// Throughput: one item per cycle while out_ready_i is high. Six register
// stages - normalise, seed table, two Newton-Raphson products, quotient
// product, round/clamp. Each stage has its own valid bit and loads when it
// is empty or the stage after it moves, so up to six items are in flight.
// Stall: with out_ready_i low the stages fill from the back and in_ready_o
// falls once every stage holds an item; nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits asynchronously; the pipeline is empty
// and accepts input in the first cycle after reset is released.
module unr_reciprocal_divider_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  unr_pkg::unr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output unr_pkg::unr_out_t out_data_o
);
  import unr_pkg::*;

  logic    s1_valid, s1_ready;
  unr_s1_t s1_data;
  logic    s4_valid, s4_ready;
  unr_s4_t s4_data;

  unr_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_data_o  (s1_data)
  );

  unr_recip u_recip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_data_i  (s1_data),
    .s4_valid_o (s4_valid),
    .s4_ready_i (s4_ready),
    .s4_data_o  (s4_data)
  );

  unr_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s4_valid_i  (s4_valid),
    .s4_ready_o  (s4_ready),
    .s4_data_i   (s4_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/unr_norm.sv =====
// Front stage: overflow test, leading-zero count and operand normalisation.
module unr_norm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  unr_pkg::unr_in_t in_data_i,
  output logic             s1_valid_o,
  input  logic             s1_ready_i,
  output unr_pkg::unr_s1_t s1_data_o
);
  import unr_pkg::*;

  logic            v1_q;
  unr_s1_t         s1_q;
  unr_s1_t         s1_d;
  logic [3:0]      sh;
  logic [NumW-1:0] nd_sh;
  logic [NumW-1:0] idx_sum;

  // Leading-zero count; a zero divisor is an overflow anyway
  always_comb begin
    sh = 4'd0;
    for (int i = 0; i < NumW; i++) begin
      if (in_data_i.divisor[i]) begin
        sh = 4'(NumW - 1 - i);
      end
    end
  end

  // Normalise and form the seed index
  always_comb begin
    nd_sh       = in_data_i.divisor << sh;
    s1_d.ovf    = ({in_data_i.divisor, 1'b0} <= {1'b0, in_data_i.numerator});
    s1_d.num    = {1'b0, in_data_i.numerator} << sh;
    s1_d.nd     = nd_sh | 16'h8000;
    idx_sum     = {1'b0, s1_d.nd[14:0]} + 16'h0040;
    s1_d.idx    = idx_sum[15:7];
  end

  assign in_ready_o = !v1_q || s1_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = v1_q;
  assign s1_data_o  = s1_q;

endmodule

// ===== src/unr_recip.sv =====
// Middle stages: seed table lookup and one Newton-Raphson refinement.
module unr_recip (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  output logic             s1_ready_o,
  input  unr_pkg::unr_s1_t s1_data_i,
  output logic             s4_valid_o,
  input  logic             s4_ready_i,
  output unr_pkg::unr_s4_t s4_data_o
);
  import unr_pkg::*;

  logic             v2_q, v3_q, v4_q;
  logic             rdy2, rdy3, rdy4;
  unr_s2_t          s2_q;
  unr_s3_t          s3_q;
  unr_s4_t          s4_q;
  logic [SeedW-1:0] seed_x [SeedRows+1];
  logic [25:0]      negd_full;
  logic [17:0]      corr;
  logic [27:0]      recip_full;

  // Seed reciprocal table, held as x = 0x101 + seed
  for (genvar n = 0; n < SeedRows; n++) begin : g_seed
    localparam int unsigned V = ((32'h40000 / (n + 256)) + 1) / 2;
    assign seed_x[n] = (V > 257) ? 10'(V) : SeedMin;
  end
  assign seed_x[SeedRows] = SeedMin;

  // Per-stage ready
  assign rdy4       = !v4_q || s4_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign s1_ready_o = rdy2;

  // Stage arithmetic
  assign negd_full  = 26'(s2_q.nd) * 26'(s2_q.x) + 26'h7F;
  assign corr       = 18'h20000 - {1'b0, s3_q.negd};
  assign recip_full = 28'(s3_q.x) * 28'(corr) + 28'h80;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= s1_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_i) begin
      s2_q.ovf <= s1_data_i.ovf;
      s2_q.num <= s1_data_i.num;
      s2_q.nd  <= s1_data_i.nd;
      s2_q.x   <= seed_x[s1_data_i.idx];
    end
    if (rdy3 && v2_q) begin
      s3_q.ovf  <= s2_q.ovf;
      s3_q.num  <= s2_q.num;
      s3_q.x    <= s2_q.x;
      s3_q.negd <= negd_full[24:8];
    end
    if (rdy4 && v3_q) begin
      s4_q.ovf   <= s3_q.ovf;
      s4_q.num   <= s3_q.num;
      s4_q.recip <= recip_full[26:8];
    end
  end

  assign s4_valid_o = v4_q;
  assign s4_data_o  = s4_q;

endmodule

// ===== src/unr_mult.sv =====
// Back stages: numerator times reciprocal, rounding, clamp and result register.
module unr_mult (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s4_valid_i,
  output logic              s4_ready_o,
  input  unr_pkg::unr_s4_t  s4_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output unr_pkg::unr_out_t out_data_o
);
  import unr_pkg::*;

  logic             v5_q, v6_q;
  logic             rdy5, rdy6;
  unr_s5_t          s5_q;
  unr_out_t         out_q;
  unr_out_t         out_d;
  logic [19:0]      q_wide;

  assign rdy6       = !v6_q || out_ready_i;
  assign rdy5       = !v5_q || rdy6;
  assign s4_ready_o = rdy5;

  // Round-off and clamp
  always_comb begin
    q_wide         = s5_q.prod[35:16];
    out_d.overflow = s5_q.ovf;
    if (s5_q.ovf || (q_wide > 20'(QuotMax))) begin
      out_d.quotient = QuotMax;
    end else begin
      out_d.quotient = q_wide[QuotW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= s4_valid_i;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && s4_valid_i) begin
      s5_q.ovf  <= s4_data_i.ovf;
      s5_q.prod <= 36'(s4_data_i.num) * 36'(s4_data_i.recip) + 36'h8000;
    end
    if (rdy6 && v5_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/unr_checker.sv =====
// Port-level checks for the reciprocal divider, bound to the top level.
module unr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input unr_pkg::unr_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input unr_pkg::unr_out_t out_data_o
);
  import unr_pkg::*;

  // A waiting input transfer stays offered with the same operands
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input withdrawn or changed while waiting");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Overflow always forces the saturated quotient
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.quotient == QuotMax)
    else $error("overflow without saturated quotient");

  // A free-running receiver never back-pressures the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with receiver ready");

endmodule

bind unr_reciprocal_divider_unit unr_checker u_unr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/unr_reciprocal_divider_unit_tb.sv =====
// Self-checking testbench for the pipelined reciprocal divider, with directed and random transfers.
module unr_reciprocal_divider_unit_tb;
  import unr_pkg::*;

  localparam int unsigned NumRows   = 23;
  localparam int unsigned NumRandom = 1200;
  localparam int unsigned ShowLimit = 10;

  // One directed row; fixed marks a result typed in by hand
  typedef struct packed {
    logic [NumW-1:0]  num;
    logic [NumW-1:0]  den;
    logic             fixed;
    logic [QuotW-1:0] quot;
    logic             ovf;
  } div_row_t;

  // Expected quotient together with the operands that produced it
  typedef struct packed {
    unr_in_t  operands;
    unr_out_t result;
  } quot_entry_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  unr_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  unr_out_t out_data_o;

  logic     drv_fixed;
  unr_out_t drv_fixed_res;
  logic     calm;

  quot_entry_t quot_pending[$];
  int unsigned mismatches;
  div_row_t    div_rows [NumRows];

  unr_reciprocal_divider_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Seed table entry, built from its index
  function automatic int unsigned seed_entry(input int unsigned idx);
    int unsigned v;
    if (idx >= SeedRows) return 0;
    v = (32'h40000 / (idx + 32'h100) + 1) / 2;
    return (v > 32'h101) ? v - 32'h101 : 0;
  endfunction

  // Quotient in 1.16 with one Newton-Raphson refinement of the table seed
  function automatic unr_out_t reciprocal_quotient(input unr_in_t item);
    int unsigned       num, den, shift, nd, idx, x, negd, recip;
    longint unsigned   prod;
    unr_out_t          res;
    num = item.numerator;
    den = item.divisor;
    if (den * 2 <= num) begin
      res.quotient = QuotMax;
      res.overflow = 1'b1;
      return res;
    end
    // den is non-zero here, so the loop ends by bit 15
    shift = 0;
    while (((den << shift) & 32'h8000) == 0) shift++;
    num   = num << shift;
    nd    = ((den << shift) | 32'h8000) & 32'hFFFF;
    idx   = ((nd & 32'h7FFF) + 32'h40) >> 7;
    x     = 32'h101 + seed_entry(idx);
    negd  = (nd * x + 32'h7F) >> 8;
    recip = (x * (32'h20000 - negd) + 32'h80) >> 8;
    prod  = (longint'(num) * longint'(recip) + 64'h8000) >> 16;
    if (prod > QuotMax) prod = QuotMax;
    res.quotient = prod[QuotW-1:0];
    res.overflow = 1'b0;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input quot_entry_t want,
                               input unr_out_t got);
    mismatches++;
    if (mismatches <= ShowLimit)
      $display("%s: num=%h den=%h expected q=%h ovf=%b, got q=%h ovf=%b", what,
               want.operands.numerator, want.operands.divisor, want.result.quotient,
               want.result.overflow, got.quotient, got.overflow);
  endtask

  // Record accepted operands and check each result transfer against the oldest one
  always @(posedge clk_i) begin
    quot_entry_t entry;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        entry.operands = in_data_i;
        entry.result   = drv_fixed ? drv_fixed_res : reciprocal_quotient(in_data_i);
        quot_pending.push_back(entry);
      end
      if (out_valid_o && out_ready_i) begin
        if (quot_pending.size() == 0) begin
          entry = '0;
          note_mismatch("unexpected result", entry, out_data_o);
        end else begin
          entry = quot_pending.pop_front();
          if (out_data_o.quotient !== entry.result.quotient ||
              out_data_o.overflow !== entry.result.overflow)
            note_mismatch("result mismatch", entry, out_data_o);
        end
      end
    end
  end

  // Result side: ready mostly high, short drops and the odd long stall
  initial begin
    int unsigned run_left;
    int unsigned r;
    logic        level;
    out_ready_i = 1'b0;
    run_left    = 0;
    level       = 1'b1;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (calm) begin
          level    = 1'b1;
          run_left = 1;
        end else if (r < 60) begin
          level    = 1'b1;
          run_left = $urandom_range(1, 8);
        end else if (r < 92) begin
          level    = 1'b0;
          run_left = $urandom_range(1, 3);
        end else begin
          level    = 1'b0;
          run_left = $urandom_range(10, 40);
        end
      end
      run_left--;
      out_ready_i <= level;
    end
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("unr_reciprocal_divider_unit_tb: FAIL");
    $finish;
  end

  // Operand side: directed rows, then random operands
  initial begin
    int unsigned num, den, lim, pick, gap, r, guard;
    logic        fixed;
    unr_out_t    fixed_res;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    drv_fixed     = 1'b0;
    drv_fixed_res = '0;
    calm          = 1'b0;
    mismatches    = 0;

    // Zero divisor, overflow boundary, zero numerator, table ends, near-2 ratios
    div_rows = '{
      '{16'h0000, 16'h0000, 1'b1, QuotMax, 1'b1},
      '{16'hFFFF, 16'h0000, 1'b1, QuotMax, 1'b1},
      '{16'h1234, 16'h0000, 1'b1, QuotMax, 1'b1},
      '{16'h0000, 16'h0001, 1'b1, 17'h00000, 1'b0},
      '{16'h0000, 16'hFFFF, 1'b1, 17'h00000, 1'b0},
      '{16'h0002, 16'h0001, 1'b1, QuotMax, 1'b1},
      '{16'hFFFE, 16'h7FFF, 1'b1, QuotMax, 1'b1},
      '{16'h0001, 16'h0001, 1'b0, 17'h0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 17'h0, 1'b0},
      '{16'hFFFD, 16'h7FFF, 1'b0, 17'h0, 1'b0},
      '{16'hFFFF, 16'h8000, 1'b0, 17'h0, 1'b0},
      '{16'h0001, 16'hFFFF, 1'b0, 17'h0, 1'b0},
      '{16'h8000, 16'h8000, 1'b0, 17'h0, 1'b0},
      '{16'h0003, 16'h0002, 1'b0, 17'h0, 1'b0},
      '{16'h0001, 16'h0002, 1'b0, 17'h0, 1'b0},
      '{16'h7FFF, 16'h4000, 1'b0, 17'h0, 1'b0},
      '{16'h00FF, 16'h0080, 1'b0, 17'h0, 1'b0},
      '{16'hAAAA, 16'h5556, 1'b0, 17'h0, 1'b0},
      '{16'h5555, 16'hAAAB, 1'b0, 17'h0, 1'b0},
      '{16'hFFFF, 16'hFFC0, 1'b0, 17'h0, 1'b0},
      '{16'h0101, 16'h0081, 1'b0, 17'h0, 1'b0},
      '{16'h1FFF, 16'h1000, 1'b0, 17'h0, 1'b0},
      '{16'h0001, 16'h0003, 1'b0, 17'h0, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumRows + NumRandom; i++) begin
      calm = (i >= NumRows) && ((((i - NumRows) / 150) % 4) == 2);
      if (i < NumRows) begin
        num       = div_rows[i].num;
        den       = div_rows[i].den;
        fixed     = div_rows[i].fixed;
        fixed_res = '{quotient: div_rows[i].quot, overflow: div_rows[i].ovf};
      end else begin
        fixed     = 1'b0;
        fixed_res = '0;
        pick      = $urandom_range(0, 9);
        // Varied leading-zero counts on the divisor
        den       = $urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15);
        lim       = (den == 0) ? 0 : 2 * den - 1;
        if (lim > 16'hFFFF) lim = 16'hFFFF;
        if (pick < 3) begin
          num = $urandom_range(0, 16'hFFFF);
          den = $urandom_range(0, 16'hFFFF);
        end else if (pick < 7) begin
          num = $urandom_range(0, lim);
        end else if (pick < 9) begin
          // ratio just under two, where the clamp bites
          num = lim - $urandom_range(0, (lim < 8) ? lim : 8);
        end else begin
          // straddle the overflow boundary
          num = 2 * den + $urandom_range(0, 2);
          num = (num == 0) ? 0 : num - 1;
          if (num > 16'hFFFF) num = 16'hFFFF;
        end
      end

      // Gap before this transfer: mostly none or short, a few long
      r = $urandom_range(0, 99);
      if (calm || r < 55) gap = 0;
      else if (r < 90)    gap = $urandom_range(1, 3);
      else                gap = $urandom_range(8, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end

      in_valid_i    <= 1'b1;
      in_data_i     <= '{numerator: num[NumW-1:0], divisor: den[NumW-1:0]};
      drv_fixed     <= fixed;
      drv_fixed_res <= fixed_res;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
    drv_fixed  <= 1'b0;
    calm        = 1'b0;

    // Drain, then allow the pipeline depth again for stray results
    guard = 0;
    while (quot_pending.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (quot_pending.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", quot_pending.size());
    end

    if (mismatches == 0) begin
      $display("unr_reciprocal_divider_unit_tb: PASS");
    end else begin
      $display("unr_reciprocal_divider_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
